>>> hdl/clt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clt_pkg
// Shared types and constants of the command line tokenizer: result kinds,
// character codes, counter limits and the per-byte result bundle.
// ----------------------------------------------------------------------------
package clt_pkg;

    localparam int LINE_BYTES_DEF  = 65536;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int MAX_RESULTS     = 3;

    localparam logic [7:0] CHR_NUL    = 8'h00;
    localparam logic [7:0] CHR_TAB    = 8'h09;
    localparam logic [7:0] CHR_SPACE  = 8'h20;
    localparam logic [7:0] CHR_DQUOTE = 8'h22;
    localparam logic [7:0] CHR_SQUOTE = 8'h27;
    localparam logic [7:0] CHR_BSLASH = 8'h5C;

    localparam logic [16:0] ARG_MAX  = 17'd65536;
    localparam logic [17:0] POOL_MAX = 18'h3FFFF;

    typedef enum logic [1:0] {
        KIND_BYTES    = 2'd0,
        KIND_END_ARG  = 2'd1,
        KIND_END_LINE = 2'd2
    } item_kind_t;

    typedef struct packed {
        item_kind_t  kind;
        logic [7:0]  chr;
        logic [16:0] rep;
    } slot_t;

    typedef struct packed {
        logic [1:0]                   cnt;
        slot_t [MAX_RESULTS-1:0]      slots;
        logic                         was_quoted;
        logic [16:0]                  arg_index;
        logic [16:0]                  total_args;
        logic [17:0]                  pool_bytes;
    } bundle_t;

endpackage
`default_nettype wire

>>> hdl/clt_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clt_front
// Per-byte tokenizer state: quoting, backslash runs, argument and pool
// counters. Turns each accepted byte into one bundle of up to three results.
// ----------------------------------------------------------------------------
module clt_front #(
    parameter int LINE_BYTES = clt_pkg::LINE_BYTES_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             take,
    input  wire logic [7:0]       line_byte,
    output clt_pkg::bundle_t      bundle,
    output logic                  bundle_valid
);

    localparam int RunCapInt = (LINE_BYTES < 65536) ? LINE_BYTES : 65536;
    localparam logic [16:0] RUN_CAP = 17'(RunCapInt);

    typedef enum logic [1:0] {
        PH_NAME = 2'd0,
        PH_GAP  = 2'd1,
        PH_ARG  = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        QC_NONE   = 2'd0,
        QC_DOUBLE = 2'd1,
        QC_SINGLE = 2'd2
    } quote_t;

    typedef enum logic [2:0] {
        ACT_CLOSE = 3'd0,
        ACT_DQ    = 3'd1,
        ACT_SQ    = 3'd2,
        ACT_SLASH = 3'd3,
        ACT_END   = 3'd4,
        ACT_BYTE  = 3'd5
    } act_t;

    phase_t      phase_reg, phase_next;
    quote_t      quote_reg, quote_next;
    logic        qflag_reg, qflag_next;
    logic        hasb_reg, hasb_next;
    logic [16:0] run_reg, run_next;
    logic [16:0] argc_reg, argc_next;
    logic [17:0] pool_reg, pool_next;

    function automatic clt_pkg::slot_t mk_slot(clt_pkg::item_kind_t kind,
                                               logic [7:0] chr, logic [16:0] rep);
        clt_pkg::slot_t s;
        s.kind = kind;
        s.chr  = chr;
        s.rep  = rep;
        return s;
    endfunction

    function automatic act_t normal_act(logic [7:0] c, quote_t q, logic hasb,
                                        logic qflag);
        logic [7:0] qc;
        logic       white;
        act_t       a;
        white = (c == clt_pkg::CHR_SPACE) || (c == clt_pkg::CHR_TAB);
        case (q)
            QC_DOUBLE: qc = clt_pkg::CHR_DQUOTE;
            QC_SINGLE: qc = clt_pkg::CHR_SQUOTE;
            default:   qc = clt_pkg::CHR_NUL;
        endcase
        if (q != QC_NONE && c == qc)
            a = ACT_CLOSE;
        else if (q == QC_NONE && c == clt_pkg::CHR_DQUOTE)
            a = ACT_DQ;
        else if (q == QC_NONE && c == clt_pkg::CHR_SQUOTE && (!hasb || qflag))
            a = ACT_SQ;
        else if (c == clt_pkg::CHR_BSLASH && q != QC_SINGLE)
            a = ACT_SLASH;
        else if (c == clt_pkg::CHR_NUL || (white && q == QC_NONE))
            a = ACT_END;
        else
            a = ACT_BYTE;
        return a;
    endfunction

    logic                                    white_c;
    logic                                    nb_run;
    quote_t                                  nb_quote;
    logic                                    nb_hasb;
    logic                                    nb_qflag;
    logic [1:0]                              k;
    clt_pkg::slot_t [clt_pkg::MAX_RESULTS-1:0] slots;
    logic [16:0]                             pool_inc;
    logic [18:0]                             pool_sum;
    logic [17:0]                             pool_sat;
    logic                                    qv;
    logic                                    eol;

    assign white_c = (line_byte == clt_pkg::CHR_SPACE) || (line_byte == clt_pkg::CHR_TAB);

    always_comb
    begin
        phase_next = phase_reg;
        quote_next = quote_reg;
        qflag_next = qflag_reg;
        hasb_next  = hasb_reg;
        run_next   = run_reg;
        argc_next  = argc_reg;
        pool_inc   = '0;
        slots      = '0;
        k          = '0;
        qv         = 1'b0;
        eol        = 1'b0;
        nb_run     = 1'b0;
        nb_quote   = quote_reg;
        nb_hasb    = hasb_reg;
        nb_qflag   = qflag_reg;

        case (phase_reg)
            PH_NAME:
            begin
                if (argc_reg == '0)
                begin
                    argc_next = 17'd1;
                    pool_inc  = 17'd1;
                end
                pool_inc = pool_inc + 17'd1;
                if (line_byte == clt_pkg::CHR_NUL)
                begin
                    slots[0]   = mk_slot(clt_pkg::KIND_END_ARG, 8'd0, 17'd0);
                    phase_next = PH_GAP;
                end
                else
                begin
                    slots[0] = mk_slot(clt_pkg::KIND_BYTES, line_byte, 17'd1);
                end
                k = 2'd1;
            end
            PH_ARG:
            begin
                if (run_reg != '0)
                begin
                    if (line_byte == clt_pkg::CHR_BSLASH)
                    begin
                        if (run_reg < RUN_CAP)
                            run_next = run_reg + 17'd1;
                    end
                    else
                    begin
                        run_next = '0;
                        if (line_byte == clt_pkg::CHR_DQUOTE)
                        begin
                            if ((run_reg >> 1) != '0)
                            begin
                                slots[k]  = mk_slot(clt_pkg::KIND_BYTES, clt_pkg::CHR_BSLASH,
                                                    run_reg >> 1);
                                k         = k + 2'd1;
                                pool_inc  = pool_inc + (run_reg >> 1);
                                hasb_next = 1'b1;
                            end
                            if (run_reg[0])
                            begin
                                slots[k]  = mk_slot(clt_pkg::KIND_BYTES, clt_pkg::CHR_DQUOTE,
                                                    17'd1);
                                k         = k + 2'd1;
                                pool_inc  = pool_inc + 17'd1;
                                hasb_next = 1'b1;
                            end
                            else
                            begin
                                nb_run  = 1'b1;
                                nb_hasb = 1'b1;
                            end
                        end
                        else
                        begin
                            slots[k]  = mk_slot(clt_pkg::KIND_BYTES, clt_pkg::CHR_BSLASH,
                                                run_reg);
                            k         = k + 2'd1;
                            pool_inc  = pool_inc + run_reg;
                            hasb_next = 1'b1;
                            nb_run    = 1'b1;
                            nb_hasb   = 1'b1;
                        end
                    end
                end
                else
                begin
                    nb_run = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_GAP;
                if (line_byte == clt_pkg::CHR_NUL)
                begin
                    slots[0] = mk_slot(clt_pkg::KIND_END_LINE, 8'd0, 17'd0);
                    k        = 2'd1;
                    eol      = 1'b1;
                end
                else if (!white_c)
                begin
                    if (argc_reg < clt_pkg::ARG_MAX)
                        argc_next = argc_reg + 17'd1;
                    pool_inc   = pool_inc + 17'd1;
                    phase_next = PH_ARG;
                    quote_next = QC_NONE;
                    qflag_next = 1'b0;
                    hasb_next  = 1'b0;
                    run_next   = '0;
                    nb_run     = 1'b1;
                    nb_quote   = QC_NONE;
                    nb_hasb    = 1'b0;
                    nb_qflag   = 1'b0;
                end
            end
        endcase

        if (nb_run)
        begin
            case (normal_act(line_byte, nb_quote, nb_hasb, nb_qflag))
                ACT_CLOSE: quote_next = QC_NONE;
                ACT_DQ:
                begin
                    quote_next = QC_DOUBLE;
                    qflag_next = 1'b1;
                end
                ACT_SQ:
                begin
                    quote_next = QC_SINGLE;
                    qflag_next = 1'b1;
                end
                ACT_SLASH: run_next = 17'd1;
                ACT_END:
                begin
                    slots[k]   = mk_slot(clt_pkg::KIND_END_ARG, 8'd0, 17'd0);
                    k          = k + 2'd1;
                    qv         = nb_qflag;
                    pool_inc   = pool_inc + 17'd1;
                    phase_next = PH_GAP;
                    quote_next = QC_NONE;
                    if (line_byte == clt_pkg::CHR_NUL)
                    begin
                        slots[k] = mk_slot(clt_pkg::KIND_END_LINE, 8'd0, 17'd0);
                        k        = k + 2'd1;
                        eol      = 1'b1;
                    end
                end
                ACT_BYTE:
                begin
                    slots[k]  = mk_slot(clt_pkg::KIND_BYTES, line_byte, 17'd1);
                    k         = k + 2'd1;
                    pool_inc  = pool_inc + 17'd1;
                    hasb_next = 1'b1;
                end
                default: ;
            endcase
        end

        pool_sum = {1'b0, pool_reg} + {2'b00, pool_inc};
        pool_sat = pool_sum[18] ? clt_pkg::POOL_MAX : pool_sum[17:0];
        pool_next = pool_sat;

        bundle.cnt        = k;
        bundle.slots      = slots;
        bundle.was_quoted = qv;
        bundle.arg_index  = (argc_next == '0) ? 17'd0 : argc_next - 17'd1;
        bundle.total_args = argc_next;
        bundle.pool_bytes = pool_sat;

        if (eol)
        begin
            phase_next = PH_NAME;
            quote_next = QC_NONE;
            qflag_next = 1'b0;
            hasb_next  = 1'b0;
            run_next   = '0;
            argc_next  = '0;
            pool_next  = '0;
        end
    end

    assign bundle_valid = take && (k != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_NAME;
            quote_reg <= QC_NONE;
            qflag_reg <= 1'b0;
            hasb_reg  <= 1'b0;
            run_reg   <= '0;
            argc_reg  <= '0;
            pool_reg  <= '0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            quote_reg <= quote_next;
            qflag_reg <= qflag_next;
            hasb_reg  <= hasb_next;
            run_reg   <= run_next;
            argc_reg  <= argc_next;
            pool_reg  <= pool_next;
        end
    end

endmodule
`default_nettype wire

>>> hdl/clt_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clt_queue
// Short first-in first-out queue of result bundles between the tokenizer
// and the result sequencer.
// ----------------------------------------------------------------------------
module clt_queue #(
    parameter int DEPTH = clt_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire clt_pkg::bundle_t  wr_data,
    output logic                   full,
    input  wire logic              rd_en,
    output clt_pkg::bundle_t       rd_data,
    output logic                   empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    clt_pkg::bundle_t mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             wr, rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign wr      = wr_en && !full;
    assign rd      = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (wr)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        if (rd)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        case ({wr, rd})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

>>> hdl/clt_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clt_back
// Result sequencer: walks the slots of the oldest bundle, one result per
// transfer, and releases the bundle after its last slot.
// ----------------------------------------------------------------------------
module clt_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire clt_pkg::bundle_t  head,
    input  wire logic              head_valid,
    output logic                   head_pop,
    input  wire logic              pop,
    output logic                   empty,
    output logic [1:0]             item_kind,
    output logic [7:0]             out_byte,
    output logic [16:0]            repeat_count,
    output logic                   was_quoted,
    output logic [16:0]            arg_index,
    output logic [16:0]            total_args,
    output logic [17:0]            pool_bytes,
    output logic                   last_of_run
);

    logic [1:0]     ptr_reg, ptr_next;
    clt_pkg::slot_t cur;
    logic           last;
    logic           xfer;

    assign cur  = head.slots[ptr_reg];
    assign last = (ptr_reg == head.cnt - 2'd1);
    assign xfer = pop && head_valid;

    assign empty        = !head_valid;
    assign head_pop     = xfer && last;
    assign item_kind    = cur.kind;
    assign out_byte     = cur.chr;
    assign repeat_count = cur.rep;
    assign was_quoted   = (cur.kind == clt_pkg::KIND_END_ARG) ? head.was_quoted : 1'b0;
    assign arg_index    = (cur.kind == clt_pkg::KIND_END_LINE) ? 17'd0 : head.arg_index;
    assign total_args   = (cur.kind == clt_pkg::KIND_END_LINE) ? head.total_args : 17'd0;
    assign pool_bytes   = (cur.kind == clt_pkg::KIND_END_LINE) ? head.pool_bytes : 18'd0;
    assign last_of_run  = last;

    always_comb
    begin
        ptr_next = ptr_reg;
        if (xfer)
            ptr_next = last ? 2'd0 : ptr_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ptr_reg <= 2'd0;
        else
            ptr_reg <= ptr_next;
    end

endmodule
`default_nettype wire

>>> hdl/command_line_tokenizer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// command_line_tokenizer
// Splits a stream of command line bytes into program name, arguments and an
// end-of-line summary.
// ----------------------------------------------------------------------------
// The block takes one command line byte per cycle while full is low; a byte
// is transferred on any edge with push high and full low. Each byte is
// classified in the cycle it arrives and leaves zero to three results,
// which wait as one entry in a QUEUE_DEPTH-entry queue. Results leave one
// per cycle while pop is high, so a stream in which each byte makes at most
// one result runs at one byte per cycle; a byte with two or three results
// holds the result side for one pop each; full rises only when the queue
// fills. A result is transferred on any edge with pop high and empty low.
// ----------------------------------------------------------------------------
module command_line_tokenizer #(
    parameter int LINE_BYTES  = clt_pkg::LINE_BYTES_DEF,
    parameter int QUEUE_DEPTH = clt_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    output logic              full,
    input  wire logic [7:0]   line_byte,
    output logic              empty,
    input  wire logic         pop,
    output logic [1:0]        item_kind,
    output logic [7:0]        out_byte,
    output logic [16:0]       repeat_count,
    output logic              was_quoted,
    output logic [16:0]       arg_index,
    output logic [16:0]       total_args,
    output logic [17:0]       pool_bytes,
    output logic              last_of_run
);

    logic             take;
    clt_pkg::bundle_t front_bundle;
    logic             front_valid;
    clt_pkg::bundle_t head;
    logic             q_empty;
    logic             head_pop;

    assign take = push && !full;

    clt_front #(
        .LINE_BYTES(LINE_BYTES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .line_byte    (line_byte),
        .bundle       (front_bundle),
        .bundle_valid (front_valid)
    );

    clt_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_valid),
        .wr_data (front_bundle),
        .full    (full),
        .rd_en   (head_pop),
        .rd_data (head),
        .empty   (q_empty)
    );

    clt_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .head_valid   (!q_empty),
        .head_pop     (head_pop),
        .pop          (pop),
        .empty        (empty),
        .item_kind    (item_kind),
        .out_byte     (out_byte),
        .repeat_count (repeat_count),
        .was_quoted   (was_quoted),
        .arg_index    (arg_index),
        .total_args   (total_args),
        .pool_bytes   (pool_bytes),
        .last_of_run  (last_of_run)
    );

endmodule
`default_nettype wire
